// ----- sv/lgcl_pkg.sv -----
package lgcl_pkg;

    // Field and datapath widths.
    localparam int COORD_W  = 32;
    localparam int CFG_W    = 25;
    localparam int LVL_OUT_W = 5;
    localparam int SUM_W    = 33;
    localparam int LEN_W    = 34;
    localparam int WIDE_W   = 36;
    localparam int DIV_STEPS = 32;

    // Cell size register reset value and floor.
    localparam logic [CFG_W-1:0] CELL_SIZE_RESET = 25'd12800;
    localparam logic [CFG_W-1:0] MIN_CELL_SIZE   = 25'd1600;

    // Level limits.
    localparam int MAX_LEVEL_DEFAULT = 31;
    localparam int LEVEL_HARD_CAP    = 39;

    // One input beat: the box corners.
    typedef struct packed {
        logic signed [COORD_W-1:0] box_min_x;
        logic signed [COORD_W-1:0] box_min_y;
        logic signed [COORD_W-1:0] box_min_z;
        logic signed [COORD_W-1:0] box_max_x;
        logic signed [COORD_W-1:0] box_max_y;
        logic signed [COORD_W-1:0] box_max_z;
    } in_beat_t;

    // One result beat: the cell that holds the box.
    typedef struct packed {
        logic signed [COORD_W-1:0] cell_x;
        logic signed [COORD_W-1:0] cell_y;
        logic signed [COORD_W-1:0] cell_z;
        logic [LVL_OUT_W-1:0]      grid_level;
        logic signed [COORD_W-1:0] cell_min_x;
        logic signed [COORD_W-1:0] cell_min_y;
        logic signed [COORD_W-1:0] cell_min_z;
        logic [COORD_W-1:0]        cell_edge;
    } out_beat_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_LEVEL,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic edge_max;
        logic level_step;
        logic prep;
        logic div_step;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic level_done;
    } status_t;

endpackage

// ----- sv/loose_grid_cell_locator.sv -----
// Channel   Ports                          Payload
// input     s_valid, s_ready, s_data       box min and max corners
// result    m_valid, m_ready, m_data       cell coordinates, level, corner, edge
// config    cfg_we, cfg_wdata              cell_size, written without wait
//
// Each box runs a level search, one level per step, with level at most 22 for
// any box, then the three bit-serial restoring dividers, which run side by side,
// one axis each; the next box is taken only after its result is loaded.
// Reset is synchronous and active low; it restores cell_size to 12800.
// A finished result waits in the output register while the next box is taken in.
// A box whose result finds that register still full waits until it is taken.
module loose_grid_cell_locator #(
    parameter int MAX_LEVEL = lgcl_pkg::MAX_LEVEL_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [lgcl_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  lgcl_pkg::in_beat_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lgcl_pkg::out_beat_t         m_data
);
    import lgcl_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    lgcl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic and result register.
    lgcl_dp #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_beat   (s_data),
        .cmd       (cmd),
        .status    (status),
        .out_beat  (m_data)
    );

endmodule

// ----- sv/lgcl_div.sv -----
module lgcl_div (
    input  logic                        aclk,
    input  logic                        start,
    input  logic                        step,
    input  logic [31:0]                 dividend,
    input  logic [lgcl_pkg::CFG_W-1:0]  divisor,
    output logic [31:0]                 quotient,
    output logic [lgcl_pkg::CFG_W-1:0]  remainder
);
    import lgcl_pkg::*;

    logic [CFG_W-1:0] rem_reg;
    logic [CFG_W-1:0] rem_next;
    logic [31:0]      quo_reg;
    logic [31:0]      quo_next;
    logic [CFG_W:0]   trial;
    logic [CFG_W+1:0] trial_diff;
    logic             fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        trial      = {rem_reg, quo_reg[31]};
        trial_diff = {1'b0, trial} - {2'b00, divisor};
        fits       = !trial_diff[CFG_W+1];
        rem_next   = fits ? trial_diff[CFG_W-1:0] : trial[CFG_W-1:0];
        quo_next   = {quo_reg[30:0], fits};
    end

    // The quotient register starts out holding the dividend and shifts it out.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- sv/lgcl_dp.sv -----
module lgcl_dp #(
    parameter int MAX_LEVEL = lgcl_pkg::MAX_LEVEL_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [lgcl_pkg::CFG_W-1:0]  cfg_wdata,
    input  lgcl_pkg::in_beat_t          in_beat,
    input  lgcl_pkg::cmd_t              cmd,
    output lgcl_pkg::status_t           status,
    output lgcl_pkg::out_beat_t         out_beat
);
    import lgcl_pkg::*;

    localparam int LEVEL_CAP_I = (MAX_LEVEL < LEVEL_HARD_CAP) ? MAX_LEVEL : LEVEL_HARD_CAP;
    localparam int LVL_W       = $clog2(LEVEL_CAP_I + 1);
    localparam int SH_W        = LVL_W + 1;
    localparam logic [LVL_W-1:0] LEVEL_CAP = LVL_W'(LEVEL_CAP_I);

    logic [CFG_W-1:0]        cell_size_reg;
    logic [CFG_W-1:0]        cs_reg;
    logic [CFG_W-1:0]        cs_eff;
    logic signed [SUM_W-1:0] sum_reg [3];
    logic [COORD_W-1:0]      edge_len_reg [3];
    logic [COORD_W-1:0]      big_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [LVL_W-1:0]        level_reg;
    logic                    neg_reg [3];
    out_beat_t               out_reg;

    logic signed [COORD_W-1:0] mn [3];
    logic signed [COORD_W-1:0] mx [3];
    logic signed [SUM_W-1:0]   sum_w [3];
    logic signed [SUM_W-1:0]   diff_w [3];
    logic [COORD_W-1:0]        edge_w [3];
    logic [COORD_W-1:0]        big_w;
    logic [SH_W-1:0]           sh;
    logic signed [SUM_W-1:0]   n_shift [3];
    logic [31:0]               dividend_w [3];
    logic [31:0]               quo_w [3];
    logic [CFG_W-1:0]          rem_w [3];
    logic [WIDE_W-1:0]         mask_w;
    logic signed [WIDE_W-1:0]  q_wide [3];
    logic [CFG_W-1:0]          r1_w [3];
    logic signed [WIDE_W-1:0]  sum_wide [3];
    logic signed [WIDE_W-1:0]  r_wide [3];
    logic signed [WIDE_W-1:0]  base_wide [3];
    logic signed [WIDE_W-1:0]  half_wide [3];
    logic [COORD_W-1:0]        q_sat [3];
    logic [COORD_W-1:0]        min_sat [3];

    // Clamp a wide signed value to the signed 32 bit range.
    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
        logic [COORD_W-1:0] res;
        if (&v[WIDE_W-1:COORD_W-1] || !(|v[WIDE_W-1:COORD_W-1])) begin
            res = v[COORD_W-1:0];
        end else if (v[WIDE_W-1]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_size_reg <= CELL_SIZE_RESET;
        end else if (cfg_we) begin
            cell_size_reg <= cfg_wdata;
        end
    end

    assign cs_eff = (cell_size_reg < MIN_CELL_SIZE) ? MIN_CELL_SIZE : cell_size_reg;

    // Per-axis centre sums and box edges; an inverted axis counts as zero.
    always_comb begin
        mn[0] = in_beat.box_min_x;
        mn[1] = in_beat.box_min_y;
        mn[2] = in_beat.box_min_z;
        mx[0] = in_beat.box_max_x;
        mx[1] = in_beat.box_max_y;
        mx[2] = in_beat.box_max_z;
        for (int i = 0; i < 3; i++) begin
            sum_w[i]  = {mn[i][COORD_W-1], mn[i]} + {mx[i][COORD_W-1], mx[i]};
            diff_w[i] = {mx[i][COORD_W-1], mx[i]} - {mn[i][COORD_W-1], mn[i]};
            edge_w[i] = diff_w[i][SUM_W-1] ? '0 : diff_w[i][COORD_W-1:0];
        end
    end

    // Largest edge of the three.
    always_comb begin
        big_w = edge_len_reg[0];
        if (edge_len_reg[1] > big_w) begin
            big_w = edge_len_reg[1];
        end
        if (edge_len_reg[2] > big_w) begin
            big_w = edge_len_reg[2];
        end
    end

    // Level search ends at the cap or once the cell covers the largest edge.
    assign status.level_done = !((level_reg < LEVEL_CAP) && (len_reg < {2'b00, big_reg}));

    // Capture, edge maximum and one level per step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
        end else if (cmd.edge_max) begin
            level_reg <= '0;
        end else if (cmd.level_step && !status.level_done) begin
            level_reg <= level_reg + LVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cs_reg <= cs_eff;
            for (int i = 0; i < 3; i++) begin
                sum_reg[i]      <= sum_w[i];
                edge_len_reg[i] <= edge_w[i];
            end
        end
        if (cmd.edge_max) begin
            big_reg <= big_w;
            len_reg <= {{(LEN_W-CFG_W){1'b0}}, cs_reg};
        end else if (cmd.level_step && !status.level_done) begin
            len_reg <= {len_reg[LEN_W-2:0], 1'b0};
        end
    end

    // Divide by two to the level plus one first; the rest goes to the dividers.
    assign sh = SH_W'(level_reg) + SH_W'(1);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_shift[i]    = sum_reg[i] >>> sh;
            dividend_w[i] = n_shift[i][SUM_W-1] ? ~n_shift[i][31:0] : n_shift[i][31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            for (int i = 0; i < 3; i++) begin
                neg_reg[i] <= n_shift[i][SUM_W-1];
            end
        end
    end

    // One divider lane per axis, stepped together.
    for (genvar g = 0; g < 3; g++) begin : g_lane
        lgcl_div u_div (
            .aclk      (aclk),
            .start     (cmd.prep),
            .step      (cmd.div_step),
            .dividend  (dividend_w[g]),
            .divisor   (cs_reg),
            .quotient  (quo_w[g]),
            .remainder (rem_w[g])
        );
    end

    // Floor quotient, full remainder and cell corner from the remainder.
    assign mask_w = ~({WIDE_W{1'b1}} << sh);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q_wide[i]    = neg_reg[i] ? ~{4'b0000, quo_w[i]} : {4'b0000, quo_w[i]};
            r1_w[i]      = neg_reg[i] ? (cs_reg - CFG_W'(1) - rem_w[i]) : rem_w[i];
            sum_wide[i]  = {{(WIDE_W-SUM_W){sum_reg[i][SUM_W-1]}}, sum_reg[i]};
            r_wide[i]    = ({{(WIDE_W-CFG_W){1'b0}}, r1_w[i]} << sh) | (sum_wide[i] & mask_w);
            base_wide[i] = sum_wide[i] - r_wide[i];
            half_wide[i] = base_wide[i] >>> 1;
            q_sat[i]     = sat_coord(q_wide[i]);
            min_sat[i]   = sat_coord(half_wide[i]);
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.cell_x     <= q_sat[0];
            out_reg.cell_y     <= q_sat[1];
            out_reg.cell_z     <= q_sat[2];
            out_reg.grid_level <= LVL_OUT_W'(level_reg);
            out_reg.cell_min_x <= min_sat[0];
            out_reg.cell_min_y <= min_sat[1];
            out_reg.cell_min_z <= min_sat[2];
            out_reg.cell_edge  <= (|len_reg[LEN_W-1:COORD_W]) ? {COORD_W{1'b1}}
                                                              : len_reg[COORD_W-1:0];
        end
    end

    assign out_beat = out_reg;

`ifndef NO_ASSERTIONS
    // The level search never runs past its cap.
    a_level_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LEVEL_CAP)
        else $error("grid level beyond cap");
`endif

endmodule

// ----- sv/lgcl_ctrl.sv -----
module lgcl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  lgcl_pkg::status_t   status,
    output lgcl_pkg::cmd_t      cmd
);
    import lgcl_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  begin
                if (s_valid) begin
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:  begin
                state_next = ST_LEVEL;
            end
            ST_LEVEL: begin
                if (status.level_done) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:  begin
                state_next = ST_DIV;
            end
            ST_DIV:   begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:   begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands and input ready.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:  begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_EDGE:  begin
                cmd.edge_max = 1'b1;
            end
            ST_LEVEL: begin
                cmd.level_step = 1'b1;
            end
            ST_PREP:  begin
                cmd.prep = 1'b1;
            end
            ST_DIV:   begin
                cmd.div_step = 1'b1;
            end
            ST_FIN:   begin
                cmd.out_load = out_free;
            end
            default:  begin
                cmd = '0;
            end
        endcase
    end

    // Divider step counter and result valid.
    always_comb begin
        cnt_next     = (state_reg == ST_DIV) ? cnt_reg + CNT_W'(1) : '0;
        m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef NO_ASSERTIONS
    // An accepted beat starts the edge step on the next cycle.
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EDGE))
        else $error("accepted beat did not start work");

    // The step counter runs only during division.
    a_cnt_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) |-> (state_reg == ST_DIV))
        else $error("divider counter active outside division");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");
`endif

endmodule

// ----- tb/loose_grid_cell_locator_tb.sv -----
module loose_grid_cell_locator_tb;
    import lgcl_pkg::*;

    localparam int          STALL_LIMIT    = 4000;
    localparam int          HOLD_CYCLES    = 600;
    localparam int          RAND_PER_PHASE = 45;
    localparam int          NUM_SIZES      = 10;
    localparam int          MAX_REPORTS    = 10;
    localparam int          DRAIN_CYCLES   = 64;
    localparam int signed   MIN32          = 32'sh80000000;
    localparam int signed   MAX32          = 32'sh7FFFFFFF;
    localparam longint      S32_MIN        = -64'sd2147483648;
    localparam longint      S32_MAX        = 64'sd2147483647;
    localparam longint      U32_MAX        = 64'sd4294967295;

    // Tracks the cell each accepted box should land in, in arrival order.
    class cell_scoreboard;
        logic [CFG_W-1:0] cell_size;
        out_beat_t        expected_cells[$];
        int               checked;
        int               errors;
        int               deepest_level;
        int               saturated_edges;

        function new();
            cell_size       = CELL_SIZE_RESET;
            checked         = 0;
            errors          = 0;
            deepest_level   = 0;
            saturated_edges = 0;
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction

        function logic signed [COORD_W-1:0] clamp_s32(longint v);
            if (v > S32_MAX) return MAX32;
            if (v < S32_MIN) return MIN32;
            return v[COORD_W-1:0];
        endfunction

        // Level search, then floor of the doubled centre over twice the cell edge.
        function out_beat_t locate(in_beat_t b);
            longint                    lo[3];
            longint                    hi[3];
            logic signed [COORD_W-1:0] coord[3];
            logic signed [COORD_W-1:0] corner[3];
            longint                    cs;
            longint                    len;
            longint                    widest;
            longint                    sum;
            longint                    den;
            longint                    q;
            int                        lvl;
            out_beat_t                 r;
            lo[0] = longint'(b.box_min_x);
            lo[1] = longint'(b.box_min_y);
            lo[2] = longint'(b.box_min_z);
            hi[0] = longint'(b.box_max_x);
            hi[1] = longint'(b.box_max_y);
            hi[2] = longint'(b.box_max_z);
            cs = longint'((cell_size < MIN_CELL_SIZE) ? MIN_CELL_SIZE : cell_size);

            // Inverted axes contribute no edge.
            widest = 0;
            for (int i = 0; i < 3; i++) begin
                if (hi[i] > lo[i] && hi[i] - lo[i] > widest) begin
                    widest = hi[i] - lo[i];
                end
            end

            lvl = 0;
            len = cs;
            while (lvl < MAX_LEVEL_DEFAULT && lvl < LEVEL_HARD_CAP && len < widest) begin
                lvl++;
                len = cs << lvl;
            end

            den = 2 * len;
            for (int i = 0; i < 3; i++) begin
                sum = lo[i] + hi[i];
                q = sum / den;
                if ((sum % den) != 0 && sum < 0) begin
                    q = q - 1;
                end
                coord[i]  = clamp_s32(q);
                corner[i] = clamp_s32(q * len);
            end

            if (lvl > deepest_level) deepest_level = lvl;
            if (len > U32_MAX) saturated_edges++;

            r.cell_x     = coord[0];
            r.cell_y     = coord[1];
            r.cell_z     = coord[2];
            r.grid_level = lvl[LVL_OUT_W-1:0];
            r.cell_min_x = corner[0];
            r.cell_min_y = corner[1];
            r.cell_min_z = corner[2];
            r.cell_edge  = (len > U32_MAX) ? 32'hFFFFFFFF : len[COORD_W-1:0];
            return r;
        endfunction

        function void note_box(in_beat_t b);
            expected_cells.push_back(locate(b));
        endfunction

        function void check_cell(out_beat_t got);
            out_beat_t want;
            string     bad;
            if (expected_cells.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: result beat with no box outstanding", $realtime);
                end
                return;
            end
            want = expected_cells.pop_front();
            checked++;
            bad = "";
            if (got.cell_x !== want.cell_x) bad = {bad, " cell_x"};
            if (got.cell_y !== want.cell_y) bad = {bad, " cell_y"};
            if (got.cell_z !== want.cell_z) bad = {bad, " cell_z"};
            if (got.grid_level !== want.grid_level) bad = {bad, " grid_level"};
            if (got.cell_min_x !== want.cell_min_x) bad = {bad, " cell_min_x"};
            if (got.cell_min_y !== want.cell_min_y) bad = {bad, " cell_min_y"};
            if (got.cell_min_z !== want.cell_min_z) bad = {bad, " cell_min_z"};
            if (got.cell_edge !== want.cell_edge) bad = {bad, " cell_edge"};
            if (bad != "") begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: cell mismatch in%s", $realtime, bad);
                    $display("  exp cell (%0d,%0d,%0d) lvl %0d min (%0d,%0d,%0d) edge %0d",
                             want.cell_x, want.cell_y, want.cell_z, want.grid_level,
                             want.cell_min_x, want.cell_min_y, want.cell_min_z,
                             want.cell_edge);
                    $display("  got cell (%0d,%0d,%0d) lvl %0d min (%0d,%0d,%0d) edge %0d",
                             got.cell_x, got.cell_y, got.cell_z, got.grid_level,
                             got.cell_min_x, got.cell_min_y, got.cell_min_z,
                             got.cell_edge);
                end
            end
        endfunction
    endclass

    bit               aclk = 1'b0;
    logic             aresetn;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             s_valid;
    logic             s_ready;
    in_beat_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_beat_t        m_data;

    cell_scoreboard   sb;
    bit               steady;
    bit               hold_req;
    int               holds_done;
    int               boxes_sent;
    int               sizes_used;
    int               quiet_cycles;

    loose_grid_cell_locator #(
        .MAX_LEVEL(MAX_LEVEL_DEFAULT)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    function automatic in_beat_t mk_box(int x0, int y0, int z0, int x1, int y1, int z1);
        in_beat_t b;
        b.box_min_x = x0;
        b.box_min_y = y0;
        b.box_min_z = z0;
        b.box_max_x = x1;
        b.box_max_y = y1;
        b.box_max_z = z1;
        return b;
    endfunction

    // Mostly well-formed boxes with spans of every magnitude; some noise and inversions.
    function automatic in_beat_t random_box();
        longint lo[3];
        longint hi[3];
        longint span;
        int     kind;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++) begin
            if (kind < 10) begin
                lo[i] = longint'($signed($urandom));
                hi[i] = longint'($signed($urandom));
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    lo[i] = longint'($signed($urandom));
                end else begin
                    lo[i] = longint'($urandom_range(0, 4000000)) - 2000000;
                end
                span = longint'($urandom >> $urandom_range(0, 31));
                if (kind >= 90 && $urandom_range(0, 1) == 1) begin
                    hi[i] = lo[i] - span - 1;
                end else begin
                    hi[i] = lo[i] + span;
                end
                if (hi[i] > S32_MAX) hi[i] = S32_MAX;
                if (hi[i] < S32_MIN) hi[i] = S32_MIN;
            end
        end
        return mk_box(lo[0][31:0], lo[1][31:0], lo[2][31:0],
                      hi[0][31:0], hi[1][31:0], hi[2][31:0]);
    endfunction

    // Offer one box and hold it until the block takes it.
    task automatic send_box(input in_beat_t b);
        int gap;
        gap = (steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        sb.note_box(b);
        boxes_sent++;
    endtask

    task automatic end_burst();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cell_size(input logic [CFG_W-1:0] v);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.cell_size = v;
        sizes_used++;
    endtask

    // Range extremes, alternating bit patterns and a fully inverted box.
    task automatic corner_boxes();
        send_box(mk_box(MIN32, MIN32, MIN32, MAX32, MAX32, MAX32));
        send_box(mk_box(MIN32, MIN32, MIN32, MIN32, MIN32, MIN32));
        send_box(mk_box(MAX32, MAX32, MAX32, MAX32, MAX32, MAX32));
        send_box(mk_box(MAX32, MAX32, MAX32, MIN32, MIN32, MIN32));
        send_box(mk_box(32'shAAAAAAAA, 32'shAAAAAAAA, 32'shAAAAAAAA,
                        32'sh55555555, 32'sh55555555, 32'sh55555555));
    endtask

    task automatic random_boxes(input int n);
        repeat (n) send_box(random_box());
    endtask

    // Results are checked as they are taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_cell(m_data);
        end
    end

    // Ends the run when no beat moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("No beat moved for %0d cycles; %0d results outstanding.",
                     quiet_cycles, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side back-pressure: random stalls, calm stretches, and the long hold-off.
    initial begin : result_sink
        int hold_left;
        int stall_left;
        int calm_left;
        int r;
        hold_left  = 0;
        stall_left = 0;
        calm_left  = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    calm_left = $urandom_range(30, 300);
                    m_ready <= 1'b1;
                end else if (r < 35) begin
                    stall_left = idle_len() - 1;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] size_plan[NUM_SIZES];
        sb           = new();
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        steady       = 1'b0;
        hold_req     = 1'b0;
        holds_done   = 0;
        boxes_sent   = 0;
        sizes_used   = 1;
        quiet_cycles = 0;

        size_plan = '{25'd0, 25'd1599, 25'd1600, 25'h1FFFFFF, 25'd1601,
                      25'd0, 25'd0, 25'd0, 25'd0, 25'd12800};
        size_plan[5] = CFG_W'($urandom_range(0, 25'h1FFFFFF));
        size_plan[6] = CFG_W'($urandom_range(1600, 200000));
        size_plan[7] = CFG_W'($urandom_range(1600, 200000));
        size_plan[8] = CFG_W'($urandom_range(200000, 25'h1FFFFFF));

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed boxes under the reset cell size.
        corner_boxes();
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        send_box(mk_box(0, 0, 0, 12800, 12800, 12800));
        send_box(mk_box(0, 0, 0, 12801, 0, 0));
        send_box(mk_box(-100, -100, -100, 100, -50, 25));
        send_box(mk_box(5000, -7, 0, -5000, 1000000, 300));
        send_box(mk_box(-1, -1, -1, 0, 0, 0));
        send_box(mk_box(-12800, -25600, -38400, -12800, -25600, -38400));
        send_box(mk_box(12799, 12800, -12801, 12799, 12800, -12801));
        send_box(mk_box(0, MIN32, 0, 0, 0, 0));
        send_box(mk_box(0, 0, -(1 << 29), 0, 0, (1 << 29) + 1));
        random_boxes(RAND_PER_PHASE);
        end_burst();

        // One phase per cell size; the third phase also fills the block against a
        // receiver that stops taking results for a long stretch.
        for (int p = 0; p < NUM_SIZES; p++) begin
            wait_drained();
            write_cell_size(size_plan[p]);
            steady = (p == 2) || ($urandom_range(0, 3) == 0);
            if (p == 2) hold_req = 1'b1;
            corner_boxes();
            random_boxes(RAND_PER_PHASE);
            end_burst();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) begin
            $display("%0d expected results never arrived.", sb.pending());
            sb.errors += sb.pending();
        end

        $display("Sent %0d boxes over %0d cell sizes; %0d results checked, %0d bad.",
                 boxes_sent, sizes_used, sb.checked, sb.errors);
        $display("Deepest level %0d, %0d saturated cell edges, %0d long result hold-off.",
                 sb.deepest_level, sb.saturated_edges, holds_done);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
